@@ src/cbd_pkg.sv @@
`timescale 1ns / 1ps

package cbd_pkg;

    localparam int COUNT_BITS_DEFAULT = 32;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_LC_X  = 8'h78;
    localparam logic [7:0] CH_UC_X  = 8'h58;

    typedef enum logic [2:0] {
        PH_START,
        PH_SIGN,
        PH_ZERO,
        PH_PREFIX,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    // number reader flags for the current size line
    typedef struct packed {
        phase_t phase;
        logic   negative;
        logic   prev_cr;
    } line_state_t;

    localparam line_state_t LINE_CLEAR = '{phase: PH_START, negative: 1'b0, prev_cr: 1'b0};

    function automatic logic is_hex(input logic [7:0] c);
        return (c inside {[CH_ZERO:CH_NINE]}) || (c inside {[CH_LC_A:CH_LC_F]})
            || (c inside {[CH_UC_A:CH_UC_F]});
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        if (c inside {[CH_ZERO:CH_NINE]})
            v = c - CH_ZERO;
        else if (c inside {[CH_LC_A:CH_LC_F]})
            v = c - CH_LC_A + 8'd10;
        else
            v = c - CH_UC_A + 8'd10;
        return v[3:0];
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
    endfunction

endpackage

@@ src/cbd_size_parser.sv @@
`timescale 1ns / 1ps

// Next-state logic for one byte of a size line: CR LF detection plus the
// strtol-style base 16 reader with saturation.
module cbd_size_parser #(
    parameter int COUNT_BITS = cbd_pkg::COUNT_BITS_DEFAULT
) (
    input  cbd_pkg::line_state_t   cur_state,
    input  logic [COUNT_BITS-1:0]  cur_acc,
    input  logic [7:0]             rx_byte,
    output cbd_pkg::line_state_t   nxt_state,
    output logic [COUNT_BITS-1:0]  nxt_acc,
    output logic                   line_end,
    output logic [COUNT_BITS-1:0]  line_size
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    function automatic logic [COUNT_BITS-1:0] accumulate(
        input logic [COUNT_BITS-1:0] acc,
        input logic [3:0]            d
    );
        logic [COUNT_BITS-1:0] dw;
        logic [COUNT_BITS-1:0] limit;
        dw    = COUNT_BITS'(d);
        limit = (COUNT_MAX - dw) >> 4;
        if (acc > limit)
            return COUNT_MAX;
        else
            return (acc << 4) | dw;
    endfunction

    function automatic void parse_char(
        input  cbd_pkg::phase_t       ph,
        input  logic                  neg,
        input  logic [COUNT_BITS-1:0] acc,
        input  logic [7:0]            c,
        output cbd_pkg::phase_t       ph_o,
        output logic                  neg_o,
        output logic [COUNT_BITS-1:0] acc_o
    );
        logic hex;
        logic lead;
        hex   = cbd_pkg::is_hex(c);
        ph_o  = ph;
        neg_o = neg;
        acc_o = acc;
        lead  = 1'b0;
        case (ph)
            cbd_pkg::PH_START:
            begin
                if (cbd_pkg::is_space(c))
                    ph_o = ph;
                else if (c == cbd_pkg::CH_PLUS)
                    ph_o = cbd_pkg::PH_SIGN;
                else if (c == cbd_pkg::CH_MINUS)
                begin
                    neg_o = 1'b1;
                    ph_o  = cbd_pkg::PH_SIGN;
                end
                else
                    lead = 1'b1;
            end
            cbd_pkg::PH_SIGN:
                lead = 1'b1;
            cbd_pkg::PH_ZERO:
            begin
                if (c == cbd_pkg::CH_LC_X || c == cbd_pkg::CH_UC_X)
                    ph_o = cbd_pkg::PH_PREFIX;
                else if (hex)
                begin
                    acc_o = accumulate(acc, cbd_pkg::hex_value(c));
                    ph_o  = cbd_pkg::PH_DIGITS;
                end
                else
                    ph_o = cbd_pkg::PH_DONE;
            end
            cbd_pkg::PH_PREFIX, cbd_pkg::PH_DIGITS:
            begin
                if (hex)
                begin
                    acc_o = accumulate(acc, cbd_pkg::hex_value(c));
                    ph_o  = cbd_pkg::PH_DIGITS;
                end
                else
                    ph_o = cbd_pkg::PH_DONE;
            end
            default:
                ph_o = ph;
        endcase
        // first character of the number proper
        if (lead)
        begin
            if (c == cbd_pkg::CH_ZERO)
                ph_o = cbd_pkg::PH_ZERO;
            else if (hex)
            begin
                acc_o = accumulate(acc, cbd_pkg::hex_value(c));
                ph_o  = cbd_pkg::PH_DIGITS;
            end
            else
                ph_o = cbd_pkg::PH_DONE;
        end
    endfunction

    cbd_pkg::phase_t       ph_a;
    logic                  neg_a;
    logic [COUNT_BITS-1:0] acc_a;
    cbd_pkg::phase_t       ph_b;
    logic                  neg_b;
    logic [COUNT_BITS-1:0] acc_b;

    always_comb
    begin
        line_end  = cur_state.prev_cr && (rx_byte == cbd_pkg::CH_LF);
        line_size = cur_state.negative ? '0 : cur_acc;

        // a held CR that is not followed by LF is an ordinary line byte
        if (cur_state.prev_cr)
            parse_char(cur_state.phase, cur_state.negative, cur_acc, cbd_pkg::CH_CR,
                       ph_a, neg_a, acc_a);
        else
        begin
            ph_a  = cur_state.phase;
            neg_a = cur_state.negative;
            acc_a = cur_acc;
        end

        parse_char(ph_a, neg_a, acc_a, rx_byte, ph_b, neg_b, acc_b);

        if (line_end)
        begin
            nxt_state = cbd_pkg::LINE_CLEAR;
            nxt_acc   = '0;
        end
        else if (rx_byte == cbd_pkg::CH_CR)
        begin
            nxt_state.phase    = ph_a;
            nxt_state.negative = neg_a;
            nxt_state.prev_cr  = 1'b1;
            nxt_acc            = acc_a;
        end
        else
        begin
            nxt_state.phase    = ph_b;
            nxt_state.negative = neg_b;
            nxt_state.prev_cr  = 1'b0;
            nxt_acc            = acc_b;
        end
    end

endmodule

@@ src/chunked_body_decoder.sv @@
`timescale 1ns / 1ps

// Pipeline: input register, then output register holding any result beat.
// Throughput: one body byte per cycle while result_stall is low; the decode
// state loop (size parser and chunk byte counter) has no extra register.
// Reset: asynchronous, active low; returns to size line mode with an empty
// parser and both pipeline registers empty.
module chunked_body_decoder #(
    parameter int COUNT_BITS = cbd_pkg::COUNT_BITS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       body_valid,
    output logic       body_stall,
    input  logic [7:0] body_byte,
    input  logic       end_of_body,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] data_byte,
    output logic       byte_valid,
    output logic       body_done
);

    typedef enum logic [1:0] {
        MODE_SIZE,
        MODE_DATA,
        MODE_SKIP
    } mode_t;

    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    mode_t                 mode_reg, mode_next;
    cbd_pkg::line_state_t  line_reg, line_next;
    logic [COUNT_BITS-1:0] acc_reg, acc_next;
    logic [COUNT_BITS-1:0] remain_reg, remain_next;

    logic       out_vld_reg;
    logic [7:0] out_byte_reg;
    logic       out_bvld_reg;
    logic       out_done_reg;

    logic advance;
    logic step;
    logic have;
    logic emit;
    logic is_crlf;

    cbd_pkg::line_state_t  p_state;
    logic [COUNT_BITS-1:0] p_acc;
    cbd_pkg::line_state_t  p_nxt_state;
    logic [COUNT_BITS-1:0] p_nxt_acc;
    logic                  p_line_end;
    logic [COUNT_BITS-1:0] p_size;
    logic [COUNT_BITS-1:0] remain_dec;

    assign advance    = !out_vld_reg || !result_stall;
    assign step       = in_vld_reg && advance;
    assign body_stall = in_vld_reg && !advance;

    assign is_crlf    = (in_byte_reg == cbd_pkg::CH_CR) || (in_byte_reg == cbd_pkg::CH_LF);
    assign remain_dec = remain_reg - COUNT_BITS'(1);

    // a byte that ends a CR/LF run starts its size line from a clean parser
    assign p_state = (mode_reg == MODE_SKIP) ? cbd_pkg::LINE_CLEAR : line_reg;
    assign p_acc   = (mode_reg == MODE_SKIP) ? '0 : acc_reg;

    cbd_size_parser #(
        .COUNT_BITS(COUNT_BITS)
    ) u_parser (
        .cur_state(p_state),
        .cur_acc  (p_acc),
        .rx_byte  (in_byte_reg),
        .nxt_state(p_nxt_state),
        .nxt_acc  (p_nxt_acc),
        .line_end (p_line_end),
        .line_size(p_size)
    );

    always_comb
    begin
        mode_next   = mode_reg;
        line_next   = line_reg;
        acc_next    = acc_reg;
        remain_next = remain_reg;
        have        = 1'b0;
        case (mode_reg)
            MODE_DATA:
            begin
                have        = 1'b1;
                remain_next = remain_dec;
                if (remain_dec == '0)
                    mode_next = MODE_SKIP;
            end
            MODE_SKIP:
            begin
                if (!is_crlf)
                begin
                    mode_next = MODE_SIZE;
                    line_next = p_nxt_state;
                    acc_next  = p_nxt_acc;
                end
            end
            default:
            begin
                mode_next = MODE_SIZE;
                line_next = p_nxt_state;
                acc_next  = p_nxt_acc;
            end
        endcase

        // size line complete: load the chunk length
        if (mode_reg != MODE_DATA && !(mode_reg == MODE_SKIP && is_crlf) && p_line_end)
        begin
            remain_next = p_size;
            mode_next   = (p_size != '0) ? MODE_DATA : MODE_SKIP;
        end

        if (in_last_reg)
        begin
            mode_next   = MODE_SIZE;
            line_next   = cbd_pkg::LINE_CLEAR;
            acc_next    = '0;
            remain_next = '0;
        end
    end

    assign emit = have || in_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            in_byte_reg  <= '0;
            in_last_reg  <= 1'b0;
            mode_reg     <= MODE_SIZE;
            line_reg     <= cbd_pkg::LINE_CLEAR;
            acc_reg      <= '0;
            remain_reg   <= '0;
            out_vld_reg  <= 1'b0;
            out_byte_reg <= '0;
            out_bvld_reg <= 1'b0;
            out_done_reg <= 1'b0;
        end
        else
        begin
            if (body_valid && !body_stall)
            begin
                in_vld_reg  <= 1'b1;
                in_byte_reg <= body_byte;
                in_last_reg <= end_of_body;
            end
            else if (step)
                in_vld_reg <= 1'b0;

            if (step)
            begin
                mode_reg   <= mode_next;
                line_reg   <= line_next;
                acc_reg    <= acc_next;
                remain_reg <= remain_next;
            end

            if (step && emit)
            begin
                out_vld_reg  <= 1'b1;
                out_byte_reg <= have ? in_byte_reg : 8'h00;
                out_bvld_reg <= have;
                out_done_reg <= in_last_reg;
            end
            else if (!result_stall)
                out_vld_reg <= 1'b0;
        end
    end

    assign result_valid = out_vld_reg;
    assign data_byte    = out_byte_reg;
    assign byte_valid   = out_bvld_reg;
    assign body_done    = out_done_reg;

endmodule
